[hdl/cds_pkg.sv]
// Shared types, codes and calendar helpers for the calendar date subtractor.
package cds_pkg;

  localparam logic signed [15:0] YEAR_MIN = 16'sh8000;
  localparam int unsigned        NW       = 19;

  // Divisibility by 25 through the modular inverse of 25 modulo 2**17.
  localparam logic [16:0] YEAR_OFS  = 17'd32800;
  localparam logic [16:0] INV25     = 17'd89129;
  localparam logic [16:0] DIV25_LIM = 17'd5242;

  typedef enum logic [2:0] {
    F_DAYS       = 3'd0,
    F_WEEKS      = 3'd1,
    F_MONTHS     = 3'd2,
    F_YEARS      = 3'd3,
    F_DECADES    = 3'd4,
    F_CENTURY    = 3'd5,
    F_MILLENNIUM = 3'd6,
    F_NONE       = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    OP_CLAMP = 2'd0,
    OP_DAY   = 2'd1,
    OP_MONTH = 2'd2,
    OP_YEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [14:0]        amount;
    logic [4:0]         in_day;
    logic [3:0]         in_month;
    logic signed [15:0] in_year;
  } in_t;

  typedef struct packed {
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic signed [15:0] out_year;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [15:0] year;
    logic [NW-1:0]      n;
  } dstate_t;

  typedef struct packed {
    logic done;
    logic sat;
  } ctl_t;

  // Gregorian rule: divisible by 4 and (not by 100, or by 400).
  function automatic logic is_leap(input logic signed [15:0] y);
    logic [16:0] u;
    logic [16:0] p;
    logic        div25;
    u     = {y[15], y} + YEAR_OFS;
    p     = u * INV25;
    div25 = (p <= DIV25_LIM);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'h0));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hdl/cds_step_unit.sv]
// Shared date step unit: one clamp, day, month or year step per cycle.
module cds_step_unit (
  input  cds_pkg::op_t     op,
  input  cds_pkg::dstate_t cur,
  output cds_pkg::dstate_t nxt,
  output cds_pkg::ctl_t    ctl
);
  import cds_pkg::*;

  logic                     leap;
  logic [3:0]               prev_m;
  logic [4:0]               cur_len;
  logic [4:0]               prev_len;
  logic [4:0]               feb_len;
  logic [8:0]               ylen;
  logic                     y_min;
  logic signed [NW:0]       ny;
  logic [NW-1:0]            day_ext;

  assign leap     = is_leap(cur.year);
  assign prev_m   = cur.month - 4'd1;
  assign cur_len  = month_days(cur.month, leap);
  assign prev_len = month_days(prev_m, leap);
  assign feb_len  = leap ? 5'd29 : 5'd28;
  assign ylen     = leap ? 9'd366 : 9'd365;
  assign y_min    = (cur.year == YEAR_MIN);
  assign ny       = {{(NW-15){cur.year[15]}}, cur.year} - $signed({1'b0, cur.n});
  assign day_ext  = {{(NW-5){1'b0}}, cur.day};

  always_comb begin
    nxt = cur;
    ctl = '0;
    unique case (op)
      OP_CLAMP: begin
        if (cur.day > cur_len) nxt.day = cur_len;
      end
      OP_DAY: begin
        if (cur.n == '0) begin
          ctl.done = 1'b1;
        end else if (day_ext > cur.n) begin
          nxt.day = cur.day - cur.n[4:0];
          nxt.n   = '0;
        end else if (cur.month == 4'd12 && cur.day == 5'd31 && !y_min &&
                     cur.n >= {{(NW-9){1'b0}}, ylen}) begin
          // skip a whole year from 31 December
          nxt.year = cur.year - 16'sd1;
          nxt.n    = cur.n - {{(NW-9){1'b0}}, ylen};
        end else if (cur.month == 4'd1) begin
          if (y_min) begin
            nxt.day   = 5'd1;
            nxt.month = 4'd1;
            ctl.done  = 1'b1;
            ctl.sat   = 1'b1;
          end else begin
            nxt.year  = cur.year - 16'sd1;
            nxt.month = 4'd12;
            nxt.day   = 5'd31;
            nxt.n     = cur.n - day_ext;
          end
        end else begin
          nxt.month = prev_m;
          nxt.day   = prev_len;
          nxt.n     = cur.n - day_ext;
        end
      end
      OP_MONTH: begin
        if (cur.n == '0) begin
          ctl.done = 1'b1;
        end else if (cur.month > 4'd2 && !y_min && cur.n >= NW'(12)) begin
          // twelve months back pass this year's February only
          nxt.year = cur.year - 16'sd1;
          nxt.n    = cur.n - NW'(12);
          if (cur.day > feb_len) nxt.day = feb_len;
        end else if (cur.month == 4'd1) begin
          if (y_min) begin
            nxt.day   = 5'd1;
            nxt.month = 4'd1;
            ctl.done  = 1'b1;
            ctl.sat   = 1'b1;
          end else begin
            nxt.year  = cur.year - 16'sd1;
            nxt.month = 4'd12;
            nxt.n     = cur.n - NW'(1);
          end
        end else begin
          nxt.month = prev_m;
          if (cur.day > prev_len) nxt.day = prev_len;
          nxt.n = cur.n - NW'(1);
        end
      end
      OP_YEAR: begin
        ctl.done = 1'b1;
        nxt.n    = '0;
        if (ny < -(NW+1)'(32768)) begin
          nxt.year = YEAR_MIN;
          ctl.sat  = 1'b1;
        end else begin
          nxt.year = ny[15:0];
        end
      end
      default: begin
        ctl.done = 1'b1;
      end
    endcase
  end

endmodule

[hdl/calendar_date_subtractor.sv]
// Calendar date subtractor top level: sequencer, state registers and result register.
// Sequence: the accepting edge loads the date and amount, S_CLAMP clamps the day, then
//   S_RUN takes one advancing step at a time until the step unit reports done. Year modes
//   finish at the first S_RUN step; day and week modes skip whole years from 31 December,
//   then step back a month at a time; month mode skips twelve months when it can, then single months.
// Throughput: one transaction at a time; in_ready rises only when the result is written, so
//   the next is not taken before then and the steps of each transaction set the rate.
// Reset: rst_n synchronous, active low; clears the sequencer and the result valid.
module calendar_date_subtractor (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cds_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cds_pkg::out_t  out_data
);
  import cds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLAMP = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t  state_r, state_nxt;
  dstate_t cur_r, cur_nxt;
  op_t     op_r, op_nxt;
  out_t    out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;

  op_t     unit_op;
  dstate_t unit_nxt;
  ctl_t    unit_ctl;

  logic [3:0]    ld_month;
  logic [4:0]    ld_day;
  logic [NW-1:0] amt;
  logic          out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // Clamp the day against the month length in the S_CLAMP state, then run the mode.
  assign unit_op = (state_r == S_CLAMP) ? OP_CLAMP : op_r;

  cds_step_unit u_step (
    .op  (unit_op),
    .cur (cur_r),
    .nxt (unit_nxt),
    .ctl (unit_ctl)
  );

  // Fix out-of-range month and zero day on load; the day clamp, which needs the leap flag, waits for S_CLAMP.
  always_comb begin
    if (in_data.in_month == 4'd0)       ld_month = 4'd1;
    else if (in_data.in_month > 4'd12)  ld_month = 4'd12;
    else                                ld_month = in_data.in_month;
    ld_day = (in_data.in_day == 5'd0) ? 5'd1 : in_data.in_day;
    amt    = {{(NW-15){1'b0}}, in_data.amount};
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    op_nxt        = op_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt.day   = ld_day;
          cur_nxt.month = ld_month;
          cur_nxt.year  = in_data.in_year;
          unique case (func_t'(in_data.func))
            F_DAYS: begin
              op_nxt    = OP_DAY;
              cur_nxt.n = amt;
            end
            F_WEEKS: begin
              op_nxt    = OP_DAY;
              cur_nxt.n = (amt << 3) - amt;
            end
            F_MONTHS: begin
              op_nxt    = OP_MONTH;
              cur_nxt.n = amt;
            end
            F_YEARS: begin
              op_nxt    = OP_YEAR;
              cur_nxt.n = amt;
            end
            F_DECADES: begin
              op_nxt    = OP_YEAR;
              cur_nxt.n = (amt << 3) + (amt << 1);
            end
            F_CENTURY: begin
              op_nxt    = OP_YEAR;
              cur_nxt.n = NW'(100);
            end
            F_MILLENNIUM: begin
              op_nxt    = OP_YEAR;
              cur_nxt.n = NW'(1000);
            end
            default: begin
              // unused mode: return the corrected date
              op_nxt    = OP_DAY;
              cur_nxt.n = '0;
            end
          endcase
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cur_nxt   = unit_nxt;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (unit_ctl.done) begin
          // hold here until the result register frees up
          if (out_free) begin
            out_nxt.out_day   = unit_nxt.day;
            out_nxt.out_month = unit_nxt.month;
            out_nxt.out_year  = unit_nxt.year;
            out_nxt.saturated = unit_ctl.sat;
            out_valid_nxt     = 1'b1;
            state_nxt         = S_IDLE;
          end
        end else begin
          cur_nxt = unit_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    op_r  <= op_nxt;
    out_r <= out_nxt;
  end

endmodule

[hdl/cds_checker.sv]
// Port-level assertions for the calendar date subtractor, bound to the top level.
module cds_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input cds_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input cds_pkg::out_t out_data
);
  import cds_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // busy right after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // clipping only ever lands on the earliest year
  a_sat_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.out_year == YEAR_MIN)
    else $error("saturated result off the year limit");

  // results always have a month in 1 to 12 and a nonzero day
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12 &&
                  out_data.out_day >= 5'd1)
    else $error("result month or day out of range");

endmodule

bind calendar_date_subtractor cds_checker u_cds_checker (.*);
